@@ rtl/gbp_pkg.sv @@
// Shared types and constants for the gshare / BTB branch predictor.
// No dependencies; used by every module under rtl/ except gbp_ram.
package gbp_pkg;

  localparam int unsigned PC_W        = 64;
  localparam int unsigned BTB_ENTRIES = 1024;
  localparam int unsigned PHT_ENTRIES = 256;
  localparam int unsigned HIST_W      = 8;
  localparam int unsigned BTB_IDX_W   = $clog2(BTB_ENTRIES);
  localparam int unsigned PHT_IDX_W   = $clog2(PHT_ENTRIES);
  // the clearing sweep covers the larger of the two memories
  localparam int unsigned CLR_ENTRIES = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
  localparam int unsigned CLR_W       = $clog2(CLR_ENTRIES);

  localparam int unsigned CTR_W = 2;
  localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;
  localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;
  localparam logic [CTR_W-1:0] CTR_TAKEN = 2'd2;

  typedef enum logic {
    FUNC_PREDICT = 1'b0,
    FUNC_UPDATE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  typedef struct packed {
    func_t             func;
    logic [PC_W-1:0]   pc;
    logic [PC_W-1:0]   target;
    logic              is_conditional;
    logic              taken;
  } in_word_t;

  typedef struct packed {
    logic [PC_W-1:0]   predicted_pc;
    logic              btb_hit;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    logic [PC_W-1:0]   tag;
    logic              conditional;
    logic [PC_W-1:0]   target;
  } btb_entry_t;

  function automatic logic [BTB_IDX_W-1:0] btb_index(input logic [PC_W-1:0] pc);
    return pc[2 +: BTB_IDX_W];
  endfunction

  // gshare: history XOR (pc >> 2), low bits
  function automatic logic [PHT_IDX_W-1:0] pht_index(input logic [HIST_W-1:0] hist,
                                                     input logic [PC_W-1:0]   pc);
    logic [PC_W-1:0] x;
    x = (pc >> 2) ^ PC_W'(hist);
    return x[PHT_IDX_W-1:0];
  endfunction

endpackage

@@ rtl/gbp_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// No package dependency.
module gbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds when re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/gbp_resolve.sv @@
// Lookup/training logic: BTB hit check, next-pc choice, counter saturation.
// Depends on gbp_pkg.
module gbp_resolve (
  input  gbp_pkg::in_word_t             item,
  input  gbp_pkg::btb_entry_t           entry,
  input  logic [gbp_pkg::CTR_W-1:0]     ctr,
  output gbp_pkg::out_word_t            pred,
  output logic [gbp_pkg::CTR_W-1:0]     ctr_nxt
);

  logic hit;
  logic use_target;

  always_comb begin
    hit        = entry.valid && (entry.tag == item.pc);
    use_target = hit && (!entry.conditional || (ctr >= gbp_pkg::CTR_TAKEN));
    pred.btb_hit      = hit;
    pred.predicted_pc = use_target ? entry.target : item.pc + gbp_pkg::PC_W'(4);
  end

  always_comb begin
    ctr_nxt = ctr;
    if (item.taken) begin
      if (ctr != gbp_pkg::CTR_MAX) begin
        ctr_nxt = ctr + gbp_pkg::CTR_W'(1);
      end
    end else begin
      if (ctr != gbp_pkg::CTR_MIN) begin
        ctr_nxt = ctr - gbp_pkg::CTR_W'(1);
      end
    end
  end

endmodule

@@ rtl/gshare_btb_branch_predictor_core.sv @@
// Branch predictor top: direct-mapped BTB plus gshare counters in two RAMs.
// Depends on gbp_pkg, gbp_ram, gbp_resolve.
//
// After reset the block sweeps both RAMs over CLR_ENTRIES (1024) addresses,
// stalling input, to clear BTB valid bits and counters. Afterwards each word
// is first read from the BTB and counter RAMs at the indexed entries, then
// looked up to form the prediction or to write back the BTB entry and the
// trained counter, since the RAMs give registered read data.
// A prediction waiting in the output register does not block the next word;
// a second prediction waits in the lookup cycle until the first is taken.
// Update words give no result.
module gshare_btb_branch_predictor_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gbp_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output gbp_pkg::out_word_t out_word
);

  gbp_pkg::state_t state_r, state_nxt;
  logic [gbp_pkg::CLR_W-1:0]     clr_r, clr_nxt;
  logic [gbp_pkg::HIST_W-1:0]    hist_r, hist_nxt;
  gbp_pkg::in_word_t             item_r;
  logic [gbp_pkg::PHT_IDX_W-1:0] pht_idx_r;
  logic                          out_valid_r, out_valid_nxt;
  gbp_pkg::out_word_t            out_word_r;

  logic                          accept;
  logic                          out_load;

  logic                          btb_we;
  logic [gbp_pkg::BTB_IDX_W-1:0] btb_waddr;
  gbp_pkg::btb_entry_t           btb_wdata;
  gbp_pkg::btb_entry_t           btb_rdata;
  logic                          pht_we;
  logic [gbp_pkg::PHT_IDX_W-1:0] pht_waddr;
  logic [gbp_pkg::CTR_W-1:0]     pht_wdata;
  logic [gbp_pkg::CTR_W-1:0]     pht_rdata;

  gbp_pkg::out_word_t            pred;
  logic [gbp_pkg::CTR_W-1:0]     ctr_nxt;

  assign in_stall  = (state_r != gbp_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  gbp_ram #(
    .WIDTH ($bits(gbp_pkg::btb_entry_t)),
    .DEPTH (gbp_pkg::BTB_ENTRIES)
  ) u_btb_ram (
    .clk   (clk),
    .we    (btb_we),
    .waddr (btb_waddr),
    .wdata (btb_wdata),
    .re    (accept),
    .raddr (gbp_pkg::btb_index(in_word.pc)),
    .rdata (btb_rdata)
  );

  gbp_ram #(
    .WIDTH (gbp_pkg::CTR_W),
    .DEPTH (gbp_pkg::PHT_ENTRIES)
  ) u_pht_ram (
    .clk   (clk),
    .we    (pht_we),
    .waddr (pht_waddr),
    .wdata (pht_wdata),
    .re    (accept),
    .raddr (gbp_pkg::pht_index(hist_r, in_word.pc)),
    .rdata (pht_rdata)
  );

  gbp_resolve u_resolve (
    .item    (item_r),
    .entry   (btb_rdata),
    .ctr     (pht_rdata),
    .pred    (pred),
    .ctr_nxt (ctr_nxt)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    hist_nxt      = hist_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    btb_we        = 1'b0;
    btb_waddr     = gbp_pkg::btb_index(item_r.pc);
    btb_wdata     = '{valid: 1'b1, tag: item_r.pc, conditional: item_r.is_conditional,
                      target: item_r.target};
    pht_we        = 1'b0;
    pht_waddr     = pht_idx_r;
    pht_wdata     = ctr_nxt;
    unique case (state_r)
      gbp_pkg::ST_CLEAR: begin
        btb_we    = 1'b1;
        btb_waddr = clr_r[gbp_pkg::BTB_IDX_W-1:0];
        btb_wdata = '0;
        pht_we    = 1'b1;
        pht_waddr = clr_r[gbp_pkg::PHT_IDX_W-1:0];
        pht_wdata = gbp_pkg::CTR_MIN;
        clr_nxt   = clr_r + gbp_pkg::CLR_W'(1);
        if (clr_r == gbp_pkg::CLR_W'(gbp_pkg::CLR_ENTRIES - 1)) begin
          state_nxt = gbp_pkg::ST_IDLE;
        end
      end
      gbp_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = gbp_pkg::ST_LOOK;
        end
      end
      gbp_pkg::ST_LOOK: begin
        if (item_r.func == gbp_pkg::FUNC_PREDICT) begin
          // hold the lookup until the output register frees up
          if (!out_valid_r || !out_stall) begin
            out_load      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = gbp_pkg::ST_IDLE;
          end
        end else begin
          btb_we    = 1'b1;
          pht_we    = item_r.is_conditional;
          if (item_r.is_conditional) begin
            hist_nxt = {hist_r[gbp_pkg::HIST_W-2:0], item_r.taken};
          end
          state_nxt = gbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gbp_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbp_pkg::ST_CLEAR;
      clr_r       <= '0;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= in_word;
      pht_idx_r <= gbp_pkg::pht_index(hist_r, in_word.pc);
    end
    if (out_load) begin
      out_word_r <= pred;
    end
  end

  // an accepted word always moves into the lookup cycle
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == gbp_pkg::ST_LOOK))
    else $error("accepted word did not enter lookup");

  // a new prediction appears only out of a lookup on a predict word
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |->
      $past(state_r == gbp_pkg::ST_LOOK && item_r.func == gbp_pkg::FUNC_PREDICT))
    else $error("result produced without a predict lookup");

  // history moves only on a conditional update
  a_hist_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (hist_r != $past(hist_r))) |->
      $past(state_r == gbp_pkg::ST_LOOK && item_r.func == gbp_pkg::FUNC_UPDATE &&
            item_r.is_conditional))
    else $error("global history changed outside a conditional update");

endmodule

@@ test/gshare_btb_branch_predictor_core_tb.sv @@
// Self-checking testbench for gshare_btb_branch_predictor_core.
// Runs directed and random predict/update traffic against an in-bench predictor of the
// BTB and gshare state. Depends on gbp_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module gshare_btb_branch_predictor_core_tb;
  import gbp_pkg::*;

  localparam int HOT_N       = 32;
  localparam int HOLD_CYCLES = 300;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_word_t   in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;

  gshare_btb_branch_predictor_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state, mirrors the block
  bit              btb_valid [BTB_ENTRIES] = '{default: 1'b0};
  bit [PC_W-1:0]   btb_tag   [BTB_ENTRIES] = '{default: '0};
  bit              btb_cond  [BTB_ENTRIES] = '{default: 1'b0};
  bit [PC_W-1:0]   btb_tgt   [BTB_ENTRIES] = '{default: '0};
  bit [CTR_W-1:0]  dir_ctr   [PHT_ENTRIES] = '{default: '0};
  bit [HIST_W-1:0] ghist = '0;

  in_word_t  pending_words[$];
  out_word_t predicted_fetch[$];
  int        words_queued  = 0;
  int        mismatches    = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        hold_req      = 0;
  int        hold_seen     = 0;
  int        hold_left     = 0;

  logic [PC_W-1:0] hot_pc  [HOT_N];
  logic [PC_W-1:0] hot_tgt [HOT_N];

  // Applies one accepted word to the predictor state; predict words queue a result.
  function automatic void train_and_predict(in_word_t w);
    logic [BTB_IDX_W-1:0] slot;
    logic [PHT_IDX_W-1:0] ctr_idx;
    logic                 hit;
    out_word_t            res;
    slot    = w.pc[2 +: BTB_IDX_W];
    ctr_idx = w.pc[2 +: PHT_IDX_W] ^ PHT_IDX_W'(ghist);
    if (w.func == FUNC_PREDICT) begin
      hit = btb_valid[slot] && (btb_tag[slot] == w.pc);
      res.btb_hit      = hit;
      res.predicted_pc = w.pc + 64'd4;
      if (hit && (!btb_cond[slot] || dir_ctr[ctr_idx] >= CTR_TAKEN))
        res.predicted_pc = btb_tgt[slot];
      predicted_fetch.push_back(res);
    end else begin
      btb_valid[slot] = 1'b1;
      btb_tag[slot]   = w.pc;
      btb_cond[slot]  = w.is_conditional;
      btb_tgt[slot]   = w.target;
      if (w.is_conditional) begin
        if (w.taken) begin
          if (dir_ctr[ctr_idx] != CTR_MAX) dir_ctr[ctr_idx] = dir_ctr[ctr_idx] + CTR_W'(1);
        end else begin
          if (dir_ctr[ctr_idx] != CTR_MIN) dir_ctr[ctr_idx] = dir_ctr[ctr_idx] - CTR_W'(1);
        end
        ghist = {ghist[HIST_W-2:0], w.taken};
      end
    end
  endfunction

  function automatic logic [PC_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_word(func_t f, logic [PC_W-1:0] pc, logic [PC_W-1:0] tgt,
                           logic c, logic t);
    in_word_t w;
    w.func           = f;
    w.pc             = pc;
    w.target         = tgt;
    w.is_conditional = c;
    w.taken          = t;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // predict word with random don't-care fields
  task automatic push_lookup(logic [PC_W-1:0] pc);
    push_word(FUNC_PREDICT, pc, rand64(), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Mostly well-formed branch traffic over a small pool of hot pcs, with some noise.
  task automatic gen_traffic(int n);
    int              stop_at;
    int              kind;
    int              i;
    int              j;
    int              k;
    logic            dir;
    logic [PC_W-1:0] pc;
    logic [PC_W-1:0] alias_pc;
    stop_at = words_queued + n;
    while (words_queued < stop_at) begin
      kind = $urandom_range(99);
      i    = $urandom_range(HOT_N - 1);
      pc   = hot_pc[i];
      if (kind < 35) begin
        // training burst; long bursts pin the history and saturate counters
        dir = 1'($urandom_range(1));
        k   = $urandom_range(1, 12);
        for (j = 0; j < k; j++)
          push_word(FUNC_UPDATE, pc, ($urandom_range(7) == 0) ? rand64() : hot_tgt[i], 1'b1,
                    ($urandom_range(4) == 0) ? !dir : dir);
        push_lookup(pc);
        if ($urandom_range(1)) push_lookup(pc);
      end else if (kind < 50) begin
        push_word(FUNC_UPDATE, pc, rand64(), 1'b0, 1'($urandom_range(1)));
        push_lookup(pc);
      end else if (kind < 60) begin
        // same BTB slot, different tag
        alias_pc = $urandom_range(1) ? pc ^ (64'd1 << $urandom_range(12, 63))
                                     : pc ^ 64'($urandom_range(1, 3));
        push_word(FUNC_UPDATE, alias_pc, rand64(), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        push_lookup(pc);
        push_lookup(alias_pc);
      end else if (kind < 80) begin
        k = $urandom_range(1, 3);
        for (j = 0; j < k; j++) push_lookup(hot_pc[$urandom_range(HOT_N - 1)]);
      end else if (kind < 90) begin
        push_word(FUNC_UPDATE, pc, hot_tgt[i], 1'b1, 1'($urandom_range(1)));
      end else begin
        push_word(func_t'($urandom_range(1)), rand64(), rand64(), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  task automatic wait_sent();
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || predicted_fetch.size() != 0)
      @(negedge clk);
  endtask

  // driver: holds a stalled word, may idle between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) train_and_predict(in_word);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && !($urandom_range(99) < send_idle_pct)) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each output word taken against the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_fetch.size() == 0) begin
          $display("%0t: unexpected word: predicted_pc=%h btb_hit=%b", $time,
                   out_word.predicted_pc, out_word.btb_hit);
          mismatches++;
        end else begin
          want = predicted_fetch.pop_front();
          if (out_word.predicted_pc !== want.predicted_pc) begin
            $display("%0t: predicted_pc mismatch: expected %h, got %h", $time,
                     want.predicted_pc, out_word.predicted_pc);
            mismatches++;
          end
          if (out_word.btb_hit !== want.btb_hit) begin
            $display("%0t: btb_hit mismatch: expected %b, got %b", $time,
                     want.btb_hit, out_word.btb_hit);
            mismatches++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    logic [PC_W-1:0] pc_a;
    logic [PC_W-1:0] pc_b;
    int              n;
    pc_a = 64'h0000_0000_0000_1000;
    pc_b = 64'hFFFF_FFFF_FFFF_FFFC;
    for (n = 0; n < HOT_N; n++) begin
      hot_pc[n]  = (n < 24) ? rand64() : hot_pc[n - 24] ^ (64'd1 << $urandom_range(12, 63));
      hot_tgt[n] = rand64();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: misses, pc + 4 wrap, tag aliasing, taken and not-taken runs, counter held at minimum
    push_lookup('0);
    push_lookup('1);
    push_word(FUNC_UPDATE, pc_a, '1, 1'b0, 1'b0);
    push_lookup(pc_a);
    push_word(FUNC_UPDATE, pc_a ^ (64'd1 << 63), '0, 1'b1, 1'b0);
    push_lookup(pc_a);
    push_lookup(pc_a ^ (64'd1 << 63));
    push_word(FUNC_UPDATE, pc_a | 64'd2, 64'h5555_5555_5555_5555, 1'b0, 1'b1);
    push_lookup(pc_a);
    push_lookup(pc_a | 64'd2);
    for (n = 0; n < 8; n++) push_word(FUNC_UPDATE, pc_b, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1);
    push_lookup(pc_b);
    for (n = 0; n < 4; n++) push_word(FUNC_UPDATE, pc_b, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
    push_lookup(pc_b);
    push_word(FUNC_UPDATE, '0, '1, 1'b1, 1'b1);
    push_lookup('0);
    wait_drained();

    // no idling; receiver holds off at the start so the block backs up
    hold_req++;
    gen_traffic(300);
    wait_sent();

    send_idle_pct = 80;
    gen_traffic(250);
    wait_drained();   // sender pause until every result is back

    send_idle_pct = 0;
    stall_pct     = 80;
    gen_traffic(300);
    wait_sent();

    send_idle_pct = 37;
    stall_pct     = 37;
    gen_traffic(300);
    wait_sent();

    send_idle_pct = 0;
    stall_pct     = 0;
    gen_traffic(175);
    wait_drained();

    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("** gshare_btb_branch_predictor_core: PASSED **");
    else
      $display("** gshare_btb_branch_predictor_core: FAILED **");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("** gshare_btb_branch_predictor_core: FAILED **");
    $finish;
  end

endmodule

@@ gshare_btb_branch_predictor_core.f @@
rtl/gbp_pkg.sv
rtl/gbp_ram.sv
rtl/gbp_resolve.sv
rtl/gshare_btb_branch_predictor_core.sv
test/gshare_btb_branch_predictor_core_tb.sv
